>>> design/hgdj_pkg.sv
package hgdj_pkg;

    // Default encoder counter width
    localparam int COUNT_BITS_DEF = 16;

    // Gear codes
    localparam logic [1:0] GEAR_NULL = 2'd0;
    localparam logic [1:0] GEAR_X1   = 2'd1;
    localparam logic [1:0] GEAR_X10  = 2'd2;
    localparam logic [1:0] GEAR_X100 = 2'd3;

    // Screen modes
    localparam logic [1:0] MODE_OTHER  = 2'd0;
    localparam logic [1:0] MODE_MAIN   = 2'd1;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    // Move amount range
    localparam int AMT_W   = 23;
    localparam int AMT_MAX = 4194303;
    localparam int AMT_MIN = -4194304;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GEAR_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_PERIOD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_X1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_X10     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_X100    = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_GEAR_PERIOD  = 8'd10;
    localparam logic [3:0] RST_SETTLE_COUNT = 4'd5;
    localparam logic [9:0] RST_POS_PERIOD   = 10'd50;
    localparam logic [7:0] RST_DEADBAND     = 8'd2;
    localparam logic [6:0] RST_MULT_X1      = 7'd1;
    localparam logic [6:0] RST_MULT_X10     = 7'd10;
    localparam logic [6:0] RST_MULT_X100    = 7'd10;

    typedef struct packed {
        logic [7:0] gear_period;
        logic [3:0] settle_count;
        logic [9:0] pos_period;
        logic [7:0] deadband;
        logic [6:0] mult_x1;
        logic [6:0] mult_x10;
        logic [6:0] mult_x100;
    } cfg_t;

    // Per-tick result of the tracking stage, before scaling
    typedef struct packed {
        logic       activity;
        logic       move_valid;
        logic       move_kind;
        logic       move_flag;
        logic [6:0] mult;
        logic [1:0] gear;
    } step_t;

endpackage

>>> design/handwheel_gear_debounce_and_jog.sv
// Handwheel gear debounce and jog interface.
// Each transfer on the s_ side is one 1 ms tick: encoder count, the two
// active-low gear pins, screen mode and the screen flag. Every tick yields
// exactly one transfer on the m_ side with the activity flag, the move
// event (valid, kind on m_tuser, flag, scaled amount) and the committed gear.
// Gear pins are sampled every gear_period+1 ticks and committed after
// settle_count further equal samples; the encoder is checked every
// pos_period ticks against the count stored at the previous check.
// A tick passes through the input register and the tracking stage,
// then is multiplied and saturated into the output register. One tick
// is taken every cycle unless a stall on m_tready has filled the stages;
// each stage is a single register that moves on whenever the stage after
// it is empty or moving. A stall on m_tready fills the stages one by one;
// s_tready drops once all three hold data. Reset clears the counters,
// gears and the first-tick flag; the first tick after reset loads the
// stored count. Registers must be written by the user through the APB
// port only while no tick is in flight; the block does not enforce it.
module handwheel_gear_debounce_and_jog
    import hgdj_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata from bit 0: encoder_count, x100_pin_n, x10_pin_n,
    // screen_mode, hp_flag, zero fill
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((COUNT_BITS+12)/8)*8-1:0]    s_tdata,
    // m_tdata from bit 0: activity, move_valid, move_flag, move_amount,
    // gear, zero fill
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,
    // m_tuser: move_kind
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int PW = (COUNT_BITS + 8 > AMT_W) ? COUNT_BITS + 8 : AMT_W;
    localparam logic signed [PW-1:0] SAT_HI = PW'(AMT_MAX);
    localparam logic signed [PW-1:0] SAT_LO = PW'(AMT_MIN);

    cfg_t                  cfg_reg;
    logic [CFG_IDX_W-1:0]  cfg_idx;

    logic                  in_valid_reg;
    logic [COUNT_BITS-1:0] in_cnt_reg;
    logic                  in_x100_reg;
    logic                  in_x10_reg;
    logic [1:0]            in_mode_reg;
    logic                  in_flag_reg;

    logic                         mid_valid_reg;
    step_t                        mid_step_reg;
    logic signed [COUNT_BITS-1:0] mid_diff_reg;

    logic                  out_valid_reg;
    logic                  out_activity_reg;
    logic                  out_move_valid_reg;
    logic                  out_move_kind_reg;
    logic                  out_move_flag_reg;
    logic [AMT_W-1:0]      out_amount_reg;
    logic [1:0]            out_gear_reg;

    logic                         adv_out;
    logic                         adv_mid;
    logic                         adv_in;
    logic                         fire_track;
    step_t                        step;
    logic signed [COUNT_BITS-1:0] step_diff;
    logic signed [COUNT_BITS+7:0] product;
    logic signed [PW-1:0]         product_ext;
    logic [AMT_W-1:0]             amount_next;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gear_period  <= RST_GEAR_PERIOD;
            cfg_reg.settle_count <= RST_SETTLE_COUNT;
            cfg_reg.pos_period   <= RST_POS_PERIOD;
            cfg_reg.deadband     <= RST_DEADBAND;
            cfg_reg.mult_x1      <= RST_MULT_X1;
            cfg_reg.mult_x10     <= RST_MULT_X10;
            cfg_reg.mult_x100    <= RST_MULT_X100;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_GEAR_PERIOD:  cfg_reg.gear_period  <= pwdata[7:0];
                REG_SETTLE_COUNT: cfg_reg.settle_count <= pwdata[3:0];
                REG_POS_PERIOD:   cfg_reg.pos_period   <= pwdata[9:0];
                REG_DEADBAND:     cfg_reg.deadband     <= pwdata[7:0];
                REG_MULT_X1:      cfg_reg.mult_x1      <= pwdata[6:0];
                REG_MULT_X10:     cfg_reg.mult_x10     <= pwdata[6:0];
                REG_MULT_X100:    cfg_reg.mult_x100    <= pwdata[6:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GEAR_PERIOD:  prdata = {24'd0, cfg_reg.gear_period};
            REG_SETTLE_COUNT: prdata = {28'd0, cfg_reg.settle_count};
            REG_POS_PERIOD:   prdata = {22'd0, cfg_reg.pos_period};
            REG_DEADBAND:     prdata = {24'd0, cfg_reg.deadband};
            REG_MULT_X1:      prdata = {25'd0, cfg_reg.mult_x1};
            REG_MULT_X10:     prdata = {25'd0, cfg_reg.mult_x10};
            REG_MULT_X100:    prdata = {25'd0, cfg_reg.mult_x100};
            default:          prdata = 32'd0;
        endcase
    end

    // Pipeline flow: a stage moves when the one after it is empty or moving
    assign adv_out    = !out_valid_reg || m_tready;
    assign adv_mid    = !mid_valid_reg || adv_out;
    assign adv_in     = !in_valid_reg || adv_mid;
    assign fire_track = in_valid_reg && adv_mid;
    assign s_tready   = adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv_mid)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Capture the tick
    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            in_cnt_reg  <= s_tdata[COUNT_BITS-1:0];
            in_x100_reg <= s_tdata[COUNT_BITS];
            in_x10_reg  <= s_tdata[COUNT_BITS+1];
            in_mode_reg <= s_tdata[COUNT_BITS+3:COUNT_BITS+2];
            in_flag_reg <= s_tdata[COUNT_BITS+4];
        end
    end

    hgdj_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire_track),
        .cnt         (in_cnt_reg),
        .x100_pin_n  (in_x100_reg),
        .x10_pin_n   (in_x10_reg),
        .screen_mode (in_mode_reg),
        .hp_flag     (in_flag_reg),
        .cfg         (cfg_reg),
        .step        (step),
        .diff        (step_diff)
    );

    // Hold the tracking result
    always_ff @(posedge clk)
    begin
        if (adv_mid)
        begin
            mid_step_reg <= step;
            mid_diff_reg <= step_diff;
        end
    end

    // Scale by the gear multiplier and clamp to the amount range
    always_comb
    begin
        product     = mid_diff_reg * $signed({1'b0, mid_step_reg.mult});
        product_ext = PW'(product);
        if (product_ext > SAT_HI)
        begin
            amount_next = SAT_HI[AMT_W-1:0];
        end
        else if (product_ext < SAT_LO)
        begin
            amount_next = SAT_LO[AMT_W-1:0];
        end
        else
        begin
            amount_next = product_ext[AMT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_activity_reg   <= mid_step_reg.activity;
            out_move_valid_reg <= mid_step_reg.move_valid;
            out_move_kind_reg  <= mid_step_reg.move_kind;
            out_move_flag_reg  <= mid_step_reg.move_flag;
            out_amount_reg     <= amount_next;
            out_gear_reg       <= mid_step_reg.gear;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_move_kind_reg;
    assign m_tdata  = {4'd0, out_gear_reg, out_amount_reg, out_move_flag_reg,
                       out_move_valid_reg, out_activity_reg};

endmodule

>>> design/hgdj_track.sv
module hgdj_track
    import hgdj_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [COUNT_BITS-1:0]        cnt,
    input  logic                         x100_pin_n,
    input  logic                         x10_pin_n,
    input  logic [1:0]                   screen_mode,
    input  logic                         hp_flag,
    input  cfg_t                         cfg,
    output step_t                        step,
    output logic signed [COUNT_BITS-1:0] diff
);

    logic [7:0]            gear_tick_reg,  gear_tick_next;
    logic [9:0]            pos_tick_reg,   pos_tick_next;
    logic [1:0]            committed_reg,  committed_next;
    logic [1:0]            candidate_reg,  candidate_next;
    logic [3:0]            settle_reg,     settle_next;
    logic [COUNT_BITS-1:0] last_count_reg, last_count_next;
    logic                  primed_reg;

    logic [COUNT_BITS-1:0]        base;
    logic [8:0]                   gear_inc;
    logic [10:0]                  pos_inc;
    logic [1:0]                   sampled;
    logic                         commit_now;
    logic                         check;
    logic signed [COUNT_BITS-1:0] raw_diff;
    logic signed [COUNT_BITS:0]   diff_ext;
    logic signed [COUNT_BITS:0]   mag;
    logic                         motion;
    logic                         move_ok;
    logic [6:0]                   mult_sel;

    // Gear debounce and position check for one tick
    always_comb
    begin
        base           = primed_reg ? last_count_reg : cnt;
        gear_tick_next = gear_tick_reg;
        candidate_next = candidate_reg;
        settle_next    = settle_reg;
        committed_next = committed_reg;
        commit_now     = 1'b0;

        // decode pins: X100 wins over X10, X1 otherwise
        if (!x100_pin_n)
        begin
            sampled = GEAR_X100;
        end
        else if (!x10_pin_n)
        begin
            sampled = GEAR_X10;
        end
        else
        begin
            sampled = GEAR_X1;
        end

        gear_inc = {1'b0, gear_tick_reg} + 9'd1;
        if (gear_inc > {1'b0, cfg.gear_period})
        begin
            gear_tick_next = '0;
            if (sampled != candidate_reg)
            begin
                candidate_next = sampled;
                settle_next    = (cfg.settle_count == 4'd0) ? 4'd1 : cfg.settle_count;
            end
            else if (settle_reg != 4'd0)
            begin
                settle_next = settle_reg - 4'd1;
                if (settle_reg == 4'd1)
                begin
                    committed_next = sampled;
                    commit_now     = 1'b1;
                end
            end
        end
        else
        begin
            gear_tick_next = gear_inc[7:0];
        end

        // wrapped difference against the stored count
        pos_inc  = {1'b0, pos_tick_reg} + 11'd1;
        check    = (pos_inc >= {1'b0, cfg.pos_period});
        raw_diff = $signed(cnt - base);
        diff_ext = (COUNT_BITS+1)'(raw_diff);
        mag      = (diff_ext < 0) ? -diff_ext : diff_ext;
        motion   = check && ($unsigned(mag) > (COUNT_BITS+1)'(cfg.deadband));

        last_count_next = check ? cnt : base;
        pos_tick_next   = check ? 10'd0 : pos_inc[9:0];

        move_ok = motion && (committed_next != GEAR_NULL)
                  && ((screen_mode == MODE_MAIN) || (screen_mode == MODE_SINGLE));

        case (committed_next)
            GEAR_X1:   mult_sel = cfg.mult_x1;
            GEAR_X10:  mult_sel = cfg.mult_x10;
            GEAR_X100: mult_sel = cfg.mult_x100;
            default:   mult_sel = 7'd0;
        endcase

        step.activity   = commit_now || motion;
        step.move_valid = move_ok;
        step.move_kind  = move_ok && (screen_mode == MODE_SINGLE);
        step.move_flag  = move_ok && hp_flag;
        step.mult       = move_ok ? mult_sel : 7'd0;
        step.gear       = committed_next;
        diff            = move_ok ? raw_diff : '0;
    end

    // Advance tracking state once per transfer into the scaling stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_tick_reg <= '0;
            pos_tick_reg  <= '0;
            committed_reg <= GEAR_NULL;
            candidate_reg <= GEAR_NULL;
            settle_reg    <= '0;
            primed_reg    <= 1'b0;
        end
        else if (fire)
        begin
            gear_tick_reg <= gear_tick_next;
            pos_tick_reg  <= pos_tick_next;
            committed_reg <= committed_next;
            candidate_reg <= candidate_next;
            settle_reg    <= settle_next;
            primed_reg    <= 1'b1;
        end
    end

    // Stored count is qualified by primed_reg
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            last_count_reg <= last_count_next;
        end
    end

endmodule

>>> dv/handwheel_gear_debounce_and_jog_test.sv
`timescale 1ns / 100ps

module handwheel_gear_debounce_and_jog_test;
    import hgdj_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int TICKS_PER_PHASE = 300;
    localparam int CYCLE_LIMIT = 200000;

    // Expected per-tick outcome of the handwheel logic
    typedef struct packed {
        logic        activity;
        logic        move_valid;
        logic        move_kind;
        logic        move_flag;
        logic [22:0] amount;
        logic [1:0]  gear;
    } tick_result_t;

    // Gear debounce and jog tracker with its own copy of the registers
    class jog_tracker;
        cfg_t            regs;
        int unsigned     gear_ticks;
        int unsigned     pos_ticks;
        logic [1:0]      committed;
        logic [1:0]      candidate;
        int unsigned     settle_left;
        logic [15:0]     last_count;
        bit              primed;
        tick_result_t    pending[$];
        int unsigned     mismatches;
        int unsigned     ticks;
        int unsigned     moves;
        int unsigned     commits;
        int unsigned     active;

        function new();
            regs = '{RST_GEAR_PERIOD, RST_SETTLE_COUNT, RST_POS_PERIOD, RST_DEADBAND,
                     RST_MULT_X1, RST_MULT_X10, RST_MULT_X100};
            gear_ticks  = 0;
            pos_ticks   = 0;
            committed   = GEAR_NULL;
            candidate   = GEAR_NULL;
            settle_left = 0;
            last_count  = '0;
            primed      = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_GEAR_PERIOD:  regs.gear_period  = val[7:0];
                REG_SETTLE_COUNT: regs.settle_count = val[3:0];
                REG_POS_PERIOD:   regs.pos_period   = val[9:0];
                REG_DEADBAND:     regs.deadband     = val[7:0];
                REG_MULT_X1:      regs.mult_x1      = val[6:0];
                REG_MULT_X10:     regs.mult_x10     = val[6:0];
                REG_MULT_X100:    regs.mult_x100    = val[6:0];
                default: ;
            endcase
        endfunction

        // Advance the tracker by one accepted tick and queue its outcome
        function void note_tick(logic [15:0] cnt, bit x100n, bit x10n, logic [1:0] mode,
                                bit flag);
            tick_result_t r;
            logic [1:0]   g;
            logic [15:0]  delta;
            int           diff;
            int           mag;
            int           mult;
            longint       product;
            r = '0;
            ticks++;
            if (!primed)
            begin
                last_count = cnt;
                primed = 1'b1;
            end

            // gear sampling, X100 wins over X10, X1 by default
            if (gear_ticks + 1 > regs.gear_period)
            begin
                gear_ticks = 0;
                g = !x100n ? GEAR_X100 : (!x10n ? GEAR_X10 : GEAR_X1);
                if (g != candidate)
                begin
                    candidate = g;
                    settle_left = (regs.settle_count != 0) ? regs.settle_count : 1;
                end
                else if (settle_left > 0)
                begin
                    settle_left--;
                    if (settle_left == 0)
                    begin
                        committed = g;
                        r.activity = 1'b1;
                        commits++;
                    end
                end
            end
            else
                gear_ticks++;

            // position check against the count stored last time
            if (pos_ticks + 1 >= regs.pos_period)
            begin
                pos_ticks = 0;
                delta = cnt - last_count;
                diff = int'($signed(delta));
                mag = (diff < 0) ? -diff : diff;
                if (mag > int'(regs.deadband))
                begin
                    r.activity = 1'b1;
                    if (committed != GEAR_NULL && (mode == MODE_MAIN || mode == MODE_SINGLE))
                    begin
                        if (committed == GEAR_X1)
                            mult = regs.mult_x1;
                        else if (committed == GEAR_X10)
                            mult = regs.mult_x10;
                        else
                            mult = regs.mult_x100;
                        product = longint'(diff) * longint'(mult);
                        if (product > AMT_MAX)
                            product = AMT_MAX;
                        if (product < AMT_MIN)
                            product = AMT_MIN;
                        r.amount = product[22:0];
                        r.move_valid = 1'b1;
                        r.move_kind = (mode == MODE_SINGLE);
                        r.move_flag = flag;
                        moves++;
                    end
                end
                last_count = cnt;
            end
            else
                pos_ticks++;

            r.gear = committed;
            if (r.activity)
                active++;
            pending.push_back(r);
        endfunction

        function void match(string field, longint exp_v, longint act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // Compare one result transfer with the oldest outstanding tick
        function void check_result(logic [31:0] data, logic kind);
            tick_result_t e;
            if (pending.size() == 0)
            begin
                $error("result transfer with no tick outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            match("activity", e.activity, data[0]);
            match("move_valid", e.move_valid, data[1]);
            match("move_flag", e.move_flag, data[2]);
            match("move_amount", $signed(e.amount), $signed(data[25:3]));
            match("gear", e.gear, data[27:26]);
            match("move_kind", e.move_kind, kind);
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    jog_tracker  sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cycles = 0;
    logic [15:0] enc = 16'h4000;
    bit          pin_x100n = 1'b1;
    bit          pin_x10n = 1'b1;

    // Register settings per phase, extremes included; phase 0 is the directed one
    cfg_t phase_cfg[7] = '{
        '{8'd0,   4'd0,  10'd0,    8'd0,   7'd1,   7'd10,  7'd100},
        '{8'd0,   4'd1,  10'd1,    8'd0,   7'd1,   7'd10,  7'd100},
        '{8'd3,   4'd15, 10'd1,    8'd255, 7'd127, 7'd0,   7'd50},
        '{8'd255, 4'd1,  10'd1023, 8'd2,   7'd1,   7'd10,  7'd10},
        '{8'd1,   4'd2,  10'd3,    8'd5,   7'd0,   7'd127, 7'd1},
        '{8'd10,  4'd5,  10'd50,   8'd2,   7'd1,   7'd10,  7'd10},
        '{8'd2,   4'd4,  10'd0,    8'd40,  7'd99,  7'd64,  7'd127}
    };

    handwheel_gear_debounce_and_jog dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check each result transfer and stall the result side at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every tick has come back, then load a phase's registers
    task automatic load_phase(input int ph);
        cfg_t c;
        c = phase_cfg[ph];
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        write_reg(REG_GEAR_PERIOD,  32'(c.gear_period));
        write_reg(REG_SETTLE_COUNT, 32'(c.settle_count));
        write_reg(REG_POS_PERIOD,   32'(c.pos_period));
        write_reg(REG_DEADBAND,     32'(c.deadband));
        write_reg(REG_MULT_X1,      32'(c.mult_x1));
        write_reg(REG_MULT_X10,     32'(c.mult_x10));
        write_reg(REG_MULT_X100,    32'(c.mult_x100));
    endtask

    task automatic send_tick(input logic [15:0] cnt, input bit x100n, input bit x10n,
                             input logic [1:0] mode, input bit flag);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, flag, mode, x10n, x100n, cnt};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(cnt, x100n, x10n, mode, flag);
    endtask

    // Mostly steady gear pins with the odd bounce, encoder moving in
    // small, medium and wrapping steps
    task automatic run_random(input int n);
        int   r;
        bit   x100n;
        bit   x10n;
        logic [1:0] mode;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                {pin_x100n, pin_x10n} = 2'($urandom_range(0, 3));
            x100n = pin_x100n;
            x10n  = pin_x10n;
            if ($urandom_range(0, 99) < 2)
                {x100n, x10n} = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r >= 98)
                enc = enc + 16'h8000;
            else if (r >= 90)
                enc = 16'($urandom);
            else if (r >= 70)
                enc = enc + 16'($urandom_range(0, 1200)) - 16'd600;
            else if (r >= 40)
                enc = enc + 16'($urandom_range(0, 16)) - 16'd8;
            mode = ($urandom_range(0, 99) < 8) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            send_tick(enc, x100n, x10n, mode, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks: gear and position evaluated on every tick
        load_phase(0);
        send_tick(16'h1234, 1'b1, 1'b1, MODE_MAIN,   1'b0);  // first tick loads the count
        send_tick(16'h1234, 1'b1, 1'b1, MODE_MAIN,   1'b0);  // X1 commits
        send_tick(16'h1235, 1'b1, 1'b1, MODE_MAIN,   1'b1);  // one step, just past deadband
        send_tick(16'h0000, 1'b1, 1'b1, MODE_SINGLE, 1'b0);
        send_tick(16'hFFFF, 1'b1, 1'b1, MODE_MAIN,   1'b1);  // wrap downwards
        send_tick(16'h0000, 1'b1, 1'b1, MODE_MAIN,   1'b0);  // wrap upwards
        send_tick(16'h8000, 1'b1, 1'b1, MODE_MAIN,   1'b1);  // exactly half the range
        send_tick(16'hFFFF, 1'b1, 1'b1, MODE_SINGLE, 1'b1);  // largest positive step
        send_tick(16'hFFFF, 1'b1, 1'b0, MODE_MAIN,   1'b0);  // X10 becomes candidate
        send_tick(16'h7FFF, 1'b1, 1'b0, MODE_OTHER,  1'b1);  // commit, motion without event
        send_tick(16'hFFFF, 1'b1, 1'b0, MODE_UNUSED, 1'b1);  // unused mode, no event
        send_tick(16'h7FFF, 1'b0, 1'b0, MODE_MAIN,   1'b1);  // X100 wins over X10
        send_tick(16'hFFFF, 1'b0, 1'b1, MODE_SINGLE, 1'b0);  // X100 commits, full scale
        send_tick(16'h7FFF, 1'b0, 1'b0, MODE_MAIN,   1'b1);
        send_tick(16'hFFFE, 1'b0, 1'b1, MODE_SINGLE, 1'b1);
        send_tick(16'hFFFE, 1'b1, 1'b1, MODE_MAIN,   1'b0);  // back to X1 candidate
        send_tick(16'hFFF0, 1'b0, 1'b1, MODE_MAIN,   1'b1);  // bounce before commit
        send_tick(16'hFFF0, 1'b1, 1'b1, MODE_SINGLE, 1'b0);
        send_tick(16'h0010, 1'b1, 1'b1, MODE_MAIN,   1'b1);
        send_tick(16'h0010, 1'b1, 1'b1, MODE_OTHER,  1'b0);

        // Random phases, rotating through the idling patterns
        for (int ph = 1; ph < 7; ph++)
        begin
            load_phase(ph);
            case ((ph - 1) % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            {pin_x100n, pin_x10n} = 2'($urandom_range(0, 3));
            run_random(TICKS_PER_PHASE);
        end

        // Drain the pipeline
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d ticks across 7 register settings and four idling patterns.",
                 sb.ticks);
        $display("Saw %0d jog moves, %0d gear commits, %0d active ticks, %0d mismatches.",
                 sb.moves, sb.commits, sb.active, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> handwheel_gear_debounce_and_jog.f
design/hgdj_pkg.sv
design/hgdj_track.sv
design/handwheel_gear_debounce_and_jog.sv
dv/handwheel_gear_debounce_and_jog_test.sv
